/* hdl/sgdr_pkg.sv */
// Package for the per-source delivery ratio estimator.
// Status codes, sequencer states and fixed-point constants; no dependencies.
package sgdr_pkg;

   typedef enum logic [1:0] {
      ST_UPDATED      = 2'd0,
      ST_ZERO_RANGE   = 2'd1,
      ST_BAD_SOURCE   = 2'd2,
      ST_OUT_OF_ORDER = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_WRITE,
      S_RD0,
      S_RD1,
      S_SCAN,
      S_CLEAR,
      S_DIVSET,
      S_DIV,
      S_STORE,
      S_OUT
   } state_type;

   localparam int PCT_W = 15;
   localparam logic [PCT_W-1:0] PCT_FIXED_ONE = 15'd25600;
   localparam int SEQ_W = 32;
   localparam int SRC_W = 8;
   // Quotient bits produced by the restoring divider (quotient < 2^15).
   localparam int DIV_STEPS = PCT_W;

endpackage

/* hdl/seq_gap_delivery_ratio.sv */
// Top level of the per-source delivery ratio estimator.
// Uses sgdr_pkg for status codes, sequencer states and constants.
//
// Each accepted transfer takes one sequence number for one source. The number is
// written into that source's ring, which sits in a single-port memory with one
// power-of-two region per source. The ring is then read back one slot per cycle,
// and one shared subtract/compare unit accumulates missed gaps and the lowest
// number. An update finishes with a restoring divider that yields one quotient
// bit per cycle; a zero range skips the divider. An out-of-order item stops the
// scan at the offending pair and then clears all RING_DEPTH slots of the ring. An
// invalid source skips the ring and goes straight to the output step. After reset
// a clearing pass writes all 2^(source bits + slot bits) memory words, 4096 with
// the default parameters, before the first transfer is taken. Only one item is in
// work at a time and req_stall is high meanwhile. A finished result waits in the
// output register until taken. The next item may be accepted while that result
// waits; its own result is held back in the output step until the register is free.
module seq_gap_delivery_ratio #(
   parameter int NUM_SOURCES = 16,
   parameter int RING_DEPTH  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_seq_number,
   input  logic [7:0]  req_source_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [14:0] rsp_ratio_percent,
   output logic        rsp_ratio_valid,
   output logic [31:0] rsp_missed_count,
   output logic [31:0] rsp_seq_range
);

   localparam int SW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int PW = $clog2(RING_DEPTH);
   localparam int AW = SW + PW;
   localparam int MEM_DEPTH = 1 << AW;
   localparam int CW = ($clog2(MEM_DEPTH + 1) > 5) ? $clog2(MEM_DEPTH + 1) : 5;

   // Ring memory, single port, registered read.
   logic [31:0] ring_mem [MEM_DEPTH];
   logic [31:0] rd_data_ff;
   logic        mem_we;
   logic [AW-1:0] mem_addr;
   logic [31:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= ring_mem[mem_addr];
   end

   // Per-source state.
   logic [PW-1:0]  wptr_ff [NUM_SOURCES];
   logic [14:0]    ratio_ff [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] known_ff;

   sgdr_pkg::state_type state_ff, state_in;
   logic [31:0] seq_ff;
   logic [SW-1:0] src_ff;
   logic        bad_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0] prev_ff;
   logic [31:0] missed_ff;
   logic [31:0] lowest_ff;
   logic        ooo_ff;
   logic [31:0] range_ff;
   logic [47:0] rem_ff;
   logic [46:0] dvs_ff;
   logic [14:0] quo_ff;
   logic        sat_ff;

   logic        out_valid_ff;
   logic [1:0]  out_status_ff;
   logic [14:0] out_ratio_ff;
   logic        out_known_ff;
   logic [31:0] out_missed_ff;
   logic [31:0] out_range_ff;

   // Reset clearing pass done flag.
   logic known_init_done;
   logic init_done_ff;
   assign known_init_done = init_done_ff;

   logic        in_fire;
   logic        out_fire;
   logic        out_load;
   assign in_fire  = req_valid && !req_stall;
   assign out_fire = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != sgdr_pkg::S_IDLE) || !init_done_ff;
   // output register is free when empty or emptied by this cycle's transfer
   assign out_load = (state_ff == sgdr_pkg::S_OUT) && (!out_valid_ff || out_fire);

   // Shared scan unit: one pair (prev, current) per cycle.
   logic        pair_ok;
   logic [32:0] gap_sum;
   logic [31:0] gap;
   assign pair_ok = (prev_ff != 32'd0) && (rd_data_ff != 32'd0);
   assign gap     = rd_data_ff - prev_ff - 32'd1;
   assign gap_sum = {1'b0, missed_ff} + {1'b0, gap};

   // Divider step.
   logic [47:0] rem_try;
   assign rem_try = rem_ff - {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sgdr_pkg::S_IDLE:   if (in_fire) state_in = sgdr_pkg::S_CHECK;
         sgdr_pkg::S_CHECK:  state_in = bad_ff ? sgdr_pkg::S_OUT : sgdr_pkg::S_WRITE;
         sgdr_pkg::S_WRITE:  state_in = sgdr_pkg::S_RD0;
         sgdr_pkg::S_RD0:    state_in = sgdr_pkg::S_RD1;
         sgdr_pkg::S_RD1:    state_in = sgdr_pkg::S_SCAN;
         sgdr_pkg::S_SCAN: begin
            if (pair_ok && prev_ff > seq_ff) state_in = sgdr_pkg::S_CLEAR;
            else if (cnt_ff == CW'(RING_DEPTH)) state_in = sgdr_pkg::S_DIVSET;
         end
         sgdr_pkg::S_CLEAR:
            if (cnt_ff == CW'(RING_DEPTH - 1)) state_in = sgdr_pkg::S_OUT;
         sgdr_pkg::S_DIVSET: state_in = (seq_ff == lowest_ff) ? sgdr_pkg::S_OUT :
                                        sgdr_pkg::S_DIV;
         sgdr_pkg::S_DIV:
            if (cnt_ff == CW'(sgdr_pkg::DIV_STEPS - 1)) state_in = sgdr_pkg::S_STORE;
         sgdr_pkg::S_STORE:  state_in = sgdr_pkg::S_OUT;
         sgdr_pkg::S_OUT:    if (out_load) state_in = sgdr_pkg::S_IDLE;
         default:            state_in = sgdr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = 32'd0;
      mem_addr  = {src_ff, cnt_ff[PW-1:0]};
      cnt_in    = cnt_ff;
      unique case (state_ff)
         sgdr_pkg::S_IDLE: begin
            if (!known_init_done) begin
               mem_we   = 1'b1;
               mem_addr = cnt_ff[AW-1:0];
               cnt_in   = cnt_ff + CW'(1);
            end else begin
               cnt_in = '0;
            end
         end
         sgdr_pkg::S_WRITE: begin
            mem_we    = 1'b1;
            mem_addr  = {src_ff, wptr_ff[src_ff]};
            mem_wdata = seq_ff;
         end
         sgdr_pkg::S_RD0: begin
            mem_addr = {src_ff, PW'(0)};
            cnt_in   = CW'(1);
         end
         sgdr_pkg::S_RD1, sgdr_pkg::S_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            if (state_ff == sgdr_pkg::S_SCAN && state_in != sgdr_pkg::S_SCAN) cnt_in = '0;
         end
         sgdr_pkg::S_CLEAR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + CW'(1);
         end
         sgdr_pkg::S_DIVSET: cnt_in = '0;
         sgdr_pkg::S_DIV:    cnt_in = cnt_ff + CW'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgdr_pkg::S_IDLE;
         cnt_ff       <= '0;
         init_done_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         known_ff     <= '0;
         for (int s = 0; s < NUM_SOURCES; s++) begin
            wptr_ff[s]  <= '0;
            ratio_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (!init_done_ff && cnt_ff == CW'(MEM_DEPTH - 1)) init_done_ff <= 1'b1;
         if (out_load) out_valid_ff <= 1'b1;
         else if (out_fire) out_valid_ff <= 1'b0;
         if (state_ff == sgdr_pkg::S_WRITE) begin
            wptr_ff[src_ff] <= (wptr_ff[src_ff] == PW'(RING_DEPTH - 1)) ? PW'(0) :
                               wptr_ff[src_ff] + PW'(1);
         end
         if (state_ff == sgdr_pkg::S_STORE) begin
            ratio_ff[src_ff] <= sat_ff ? 15'd0 : quo_ff;
            known_ff[src_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         sgdr_pkg::S_IDLE: begin
            seq_ff <= req_seq_number;
            bad_ff <= ({24'd0, req_source_id} >= 32'(NUM_SOURCES));
            src_ff <= req_source_id[SW-1:0];
         end
         sgdr_pkg::S_RD1: begin
            missed_ff <= '0;
            lowest_ff <= seq_ff;
            ooo_ff    <= 1'b0;
         end
         sgdr_pkg::S_SCAN: begin
            if (pair_ok) begin
               if (rd_data_ff > prev_ff) missed_ff <= gap_sum[32] ? 32'hFFFF_FFFF :
                                                      gap_sum[31:0];
               if (prev_ff < lowest_ff) lowest_ff <= prev_ff;
               if (prev_ff > seq_ff) ooo_ff <= 1'b1;
            end
         end
         sgdr_pkg::S_DIVSET: begin
            range_ff <= seq_ff - lowest_ff;
            sat_ff   <= missed_ff >= (seq_ff - lowest_ff);
            // numerator = (range - missed) * 25600, loaded before the divider steps
            rem_ff   <= 48'((seq_ff - lowest_ff) - missed_ff) * 48'(sgdr_pkg::PCT_FIXED_ONE);
            dvs_ff   <= {(seq_ff - lowest_ff), 15'd0} >> 1;
            quo_ff   <= '0;
         end
         sgdr_pkg::S_DIV: begin
            if (!rem_try[47]) begin
               rem_ff <= rem_try;
               quo_ff <= {quo_ff[13:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[13:0], 1'b0};
            end
            dvs_ff <= dvs_ff >> 1;
         end
         default: ;
      endcase
      // prev tracks the slot before the one now in rd_data_ff
      if (state_ff == sgdr_pkg::S_RD1 || state_ff == sgdr_pkg::S_SCAN) prev_ff <= rd_data_ff;
      if (out_load) begin
         out_missed_ff <= '0;
         out_range_ff  <= '0;
         out_ratio_ff  <= bad_ff ? 15'd0 : ratio_ff[src_ff];
         out_known_ff  <= bad_ff ? 1'b0 : known_ff[src_ff];
         if (bad_ff) out_status_ff <= sgdr_pkg::ST_BAD_SOURCE;
         else if (ooo_ff) out_status_ff <= sgdr_pkg::ST_OUT_OF_ORDER;
         else if (seq_ff == lowest_ff) begin
            out_status_ff <= sgdr_pkg::ST_ZERO_RANGE;
            out_missed_ff <= missed_ff;
         end else begin
            out_status_ff <= sgdr_pkg::ST_UPDATED;
            out_missed_ff <= missed_ff;
            out_range_ff  <= range_ff;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_ratio_percent = out_ratio_ff;
   assign rsp_ratio_valid   = out_known_ff;
   assign rsp_missed_count  = out_missed_ff;
   assign rsp_seq_range     = out_range_ff;

   // No transfer taken before the clearing pass has finished.
   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      !init_done_ff |-> !in_fire) else $error("transfer during clear");
   // A result appears only after the output step.
   a_out_after_step: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == sgdr_pkg::S_OUT)
      else $error("spurious result");
   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_ratio_percent) && $stable(rsp_ratio_valid)
         && $stable(rsp_missed_count) && $stable(rsp_seq_range))
      else $error("stalled result changed");

endmodule

/* tb/tb_seq_gap_delivery_ratio.sv */
// Testbench for seq_gap_delivery_ratio: a directed table, then random sequence streams,
// with each result checked against the table's own entry or a behavioral estimator.
// Depends on sgdr_pkg and the seq_gap_delivery_ratio RTL.
`timescale 1ns / 100ps

module tb_seq_gap_delivery_ratio;

   localparam int NSRC  = 16;
   localparam int DEPTH = 256;
   localparam int RANDOM_ITEMS = 1030;

   typedef struct {
      sgdr_pkg::status_type status;
      logic [14:0] ratio;
      logic        known;
      logic [31:0] missed;
      logic [31:0] span;
   } ratio_result_type;

   typedef struct {
      logic [31:0]      seq;
      logic [7:0]       src;
      bit               typed;
      ratio_result_type res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_seq_number = '0;
   logic [7:0]  req_source_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [1:0]  rsp_status;
   logic [14:0] rsp_ratio_percent;
   logic        rsp_ratio_valid;
   logic [31:0] rsp_missed_count;
   logic [31:0] rsp_seq_range;

   // estimator state
   logic [31:0] seq_hist [NSRC][DEPTH];
   logic [7:0]  hist_ptr [NSRC];
   logic [14:0] ratio_held [NSRC];
   logic        ratio_set [NSRC];
   logic [31:0] last_seq [NSRC];

   ratio_result_type expected_ratios [$];
   int fail_count = 0;
   int burst_left = 0;

   always #2 clock = ~clock;

   seq_gap_delivery_ratio #(.NUM_SOURCES(NSRC), .RING_DEPTH(DEPTH)) uut (.*);

   function automatic ratio_result_type estimate_ratio(logic [31:0] seq, logic [7:0] src);
      ratio_result_type r;
      logic [63:0]   missed;
      logic [31:0]   lowest;
      logic [31:0]   cur;
      logic [31:0]   nxt;
      logic [63:0]   num;
      r = '{sgdr_pkg::ST_BAD_SOURCE, '0, 1'b0, '0, '0};
      missed = '0;
      lowest = seq;
      if (src >= NSRC)
         return r;
      seq_hist[src][hist_ptr[src]] = seq;
      hist_ptr[src] = hist_ptr[src] + 8'd1;
      for (int i = 0; i < DEPTH - 1; i++) begin
         cur = seq_hist[src][i];
         nxt = seq_hist[src][i+1];
         if (cur == 0 || nxt == 0)
            continue;
         if (nxt > cur) begin
            missed = missed + 64'(nxt - cur - 32'd1);
            if (missed > 64'hFFFF_FFFF)
               missed = 64'hFFFF_FFFF;
         end
         if (cur < lowest)
            lowest = cur;
         if (cur > seq) begin
            // out of order: only this source's ring is emptied
            for (int j = 0; j < DEPTH; j++)
               seq_hist[src][j] = '0;
            return '{sgdr_pkg::ST_OUT_OF_ORDER, ratio_held[src], ratio_set[src], '0, '0};
         end
      end
      r.span = seq - lowest;
      r.missed = missed[31:0];
      if (r.span == 0) begin
         r.status = sgdr_pkg::ST_ZERO_RANGE;
         r.ratio = ratio_held[src];
         r.known = ratio_set[src];
         return r;
      end
      if (missed >= 64'(r.span)) begin
         ratio_held[src] = '0;
      end else begin
         num = (64'(r.span) - missed) * 64'(sgdr_pkg::PCT_FIXED_ONE);
         ratio_held[src] = 15'(num / 64'(r.span));
      end
      ratio_set[src] = 1'b1;
      r.status = sgdr_pkg::ST_UPDATED;
      r.ratio = ratio_held[src];
      r.known = 1'b1;
      return r;
   endfunction

   // drive one transfer, holding it until taken; sender bursts and gaps are handled here
   task automatic send_packet(logic [31:0] seq, logic [7:0] src, bit typed,
                              ratio_result_type res);
      ratio_result_type r;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_seq_number <= seq;
      req_source_id <= src;
      do @(posedge clock); while (req_stall);
      r = estimate_ratio(seq, src);
      expected_ratios.push_back(typed ? res : r);
      if (src < NSRC)
         last_seq[src] = seq;
      @(negedge clock);
   endtask

   // receiver stall pattern: runs of no stall, light and heavy stalling
   initial begin
      int mode;
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(50, 2000)) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      ratio_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ratios.size() == 0) begin
            $error("unexpected transfer, status %0d", rsp_status);
            fail_count++;
         end else begin
            e = expected_ratios.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_status);
               fail_count++;
            end
            if (rsp_ratio_percent !== e.ratio) begin
               $error("ratio_percent: expected %0d, actual %0d", e.ratio, rsp_ratio_percent);
               fail_count++;
            end
            if (rsp_ratio_valid !== e.known) begin
               $error("ratio_valid: expected %0d, actual %0d", e.known, rsp_ratio_valid);
               fail_count++;
            end
            if (rsp_missed_count !== e.missed) begin
               $error("missed_count: expected %0h, actual %0h", e.missed, rsp_missed_count);
               fail_count++;
            end
            if (rsp_seq_range !== e.span) begin
               $error("seq_range: expected %0h, actual %0h", e.span, rsp_seq_range);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #12ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      stim_row_type     directed [$];
      ratio_result_type none;
      logic [31:0]      seq;
      logic [7:0]       src;
      int               pick;
      none = '{sgdr_pkg::ST_UPDATED, '0, 1'b0, '0, '0};
      for (int s = 0; s < NSRC; s++) begin
         hist_ptr[s] = '0;
         ratio_held[s] = '0;
         ratio_set[s] = 1'b0;
         last_seq[s] = 32'd1;
         for (int i = 0; i < DEPTH; i++)
            seq_hist[s][i] = '0;
      end
      directed = '{
         '{32'd5,          8'd0,   1, '{sgdr_pkg::ST_ZERO_RANGE, '0, 1'b0, '0, '0}},
         '{32'd0,          8'd255, 1, '{sgdr_pkg::ST_BAD_SOURCE, '0, 1'b0, '0, '0}},
         '{32'hFFFF_FFFF,  8'd16,  1, '{sgdr_pkg::ST_BAD_SOURCE, '0, 1'b0, '0, '0}},
         '{32'd6,          8'd0,   1,
           '{sgdr_pkg::ST_UPDATED, sgdr_pkg::PCT_FIXED_ONE, 1'b1, '0, 32'd1}},
         '{32'd10,         8'd0,   0, none},
         '{32'd3,          8'd0,   0, none},    // lower than ring: ring cleared
         '{32'd0,          8'd1,   1, '{sgdr_pkg::ST_ZERO_RANGE, '0, 1'b0, '0, '0}},
         '{32'hFFFF_FFFF,  8'd1,   0, none},
         '{32'd7,          8'd0,   0, none},
         '{32'd7,          8'd0,   0, none},    // duplicate: zero range keeps ratio
         '{32'd8,          8'd0,   0, none},
         '{32'h8000_0000,  8'd15,  0, none},
         '{32'hFFFF_FFFF,  8'd15,  0, none},
         '{32'd1,          8'd15,  0, none},
         '{32'h5555_5555,  8'd170, 1, '{sgdr_pkg::ST_BAD_SOURCE, '0, 1'b0, '0, '0}},
         '{32'hAAAA_AAAA,  8'd2,   0, none},
         '{32'hAAAA_AAB0,  8'd2,   0, none},
         '{32'hAAAA_AAB1,  8'd2,   0, none},
         '{32'd0,          8'd2,   0, none},    // empty mark written into a live ring
         '{32'hAAAA_AAB5,  8'd2,   0, none}
      };
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[k])
         send_packet(directed[k].seq, directed[k].src, directed[k].typed, directed[k].res);

      // mixed streams with bad sources, repeats, drops, zeros and jumps, heavy on source 0 so its ring wraps
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         src = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, NSRC - 1));
         pick = $urandom_range(0, 99);
         if (pick < 7) begin
            src = 8'($urandom_range(NSRC, 255));
            seq = $urandom;
         end else if (pick < 55)
            seq = last_seq[src] + 32'd1;
         else if (pick < 72)
            seq = last_seq[src] + 32'($urandom_range(2, 6));
         else if (pick < 76)
            seq = last_seq[src] + $urandom_range(0, 32'h3FFF_FFFF);
         else if (pick < 81)
            seq = last_seq[src];
         else if (pick < 87)
            seq = last_seq[src] - 32'($urandom_range(1, 50));
         else if (pick < 91)
            seq = '0;
         else if (pick < 95)
            seq = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
         else
            seq = $urandom;
         send_packet(seq, src, 0, none);
      end
      req_valid <= 1'b0;
      while (expected_ratios.size() != 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
